// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// clocked check that a condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// ----- hdl/lsm_pkg.sv -----
// types and constants of the multi-pop stack
`timescale 1ns / 1ps

package lsm_pkg;

    localparam int WORD_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [COUNT_W-1:0] MAX_RESULTS = 7'd64;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MPOP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNF   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_MPOP
    } t_state;

    // shift controls broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

// ----- hdl/lsm_cell.sv -----
// one stack cell: holds a word, shifts down on push and up on pop
`timescale 1ns / 1ps

module lsm_cell (
    input  logic                              i_clk,
    input  lsm_pkg::t_shift                   i_ctl,
    input  logic signed [lsm_pkg::WORD_W-1:0] i_from_up,
    input  logic signed [lsm_pkg::WORD_W-1:0] i_from_dn,
    output logic signed [lsm_pkg::WORD_W-1:0] o_word
);

    logic signed [lsm_pkg::WORD_W-1:0] r_word;
    logic signed [lsm_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.push) begin
            n_word = i_from_up;
        end else if (i_ctl.pop) begin
            n_word = i_from_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- hdl/lifo_stack_with_multi_pop.sv -----
// Bounded LIFO of signed 32-bit words with push, pop and multi-pop commands.
// Input channel: i_in_valid / o_in_stall carry i_cmd, i_push_value and
// i_pop_count; a transfer happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry o_word_out, o_word_valid,
// o_status and o_last; o_last marks the final result of a command.
// The words sit in a chain of cells, top of stack in cell 0; every cell moves
// its word to a neighbor on push (down) and pop (up), so each push or pop step
// moves the whole stack in one shift.
// Push and pop: the result is written to the output register at the transfer,
// and a new command can be taken every cycle while the output is not stalled.
// Multi-pop of n words: n results, one per cycle while the output is not stalled,
// the first written at the transfer; the input stalls while the rest stream out.
// Command code 3 is dropped with no result.
// Reset is synchronous; it empties the stack and clears the output valid flag.
// While the receiver stalls, the output register holds and the input channel
// stalls too; no result is lost.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lifo_stack_with_multi_pop #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lsm_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [lsm_pkg::WORD_W-1:0]   i_push_value,
    input  logic [lsm_pkg::COUNT_W-1:0]         i_pop_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lsm_pkg::WORD_W-1:0]   o_word_out,
    output logic                                o_word_valid,
    output logic [lsm_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_last
);

    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (FW > lsm_pkg::COUNT_W) ? FW : lsm_pkg::COUNT_W;

    logic signed [lsm_pkg::WORD_W-1:0] cell_word [STACK_DEPTH];

    lsm_pkg::t_state r_state;
    lsm_pkg::t_state n_state;
    logic [FW-1:0]                 r_fill;
    logic [FW-1:0]                 n_fill;
    logic [lsm_pkg::COUNT_W-1:0]   r_remain;
    logic [lsm_pkg::COUNT_W-1:0]   n_remain;
    logic                          r_short;
    logic                          n_short;

    logic                              r_out_valid;
    logic signed [lsm_pkg::WORD_W-1:0] r_word_out;
    logic                              r_word_valid;
    logic [lsm_pkg::STATUS_W-1:0]      r_status;
    logic                              r_last;

    lsm_pkg::t_shift                   shift;
    logic                              emit;
    logic signed [lsm_pkg::WORD_W-1:0] e_word;
    logic                              e_valid;
    logic [lsm_pkg::STATUS_W-1:0]      e_status;
    logic                              e_last;

    logic                        out_free;
    logic                        in_take;
    logic                        full;
    logic                        empty;
    logic [lsm_pkg::COUNT_W-1:0] cnt_sat;
    logic [CW-1:0]               cnt_w;
    logic [CW-1:0]               fill_w;
    logic [lsm_pkg::COUNT_W-1:0] n_pop;
    logic                        shortfall;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_take    = (r_state == lsm_pkg::S_IDLE) && i_in_valid && out_free;
    assign o_in_stall = (r_state != lsm_pkg::S_IDLE) || !out_free;

    assign full  = (r_fill == FW'(STACK_DEPTH));
    assign empty = (r_fill == '0);

    // multi-pop size: count capped at the result limit, then at the fill level
    assign cnt_sat   = (i_pop_count > lsm_pkg::MAX_RESULTS) ? lsm_pkg::MAX_RESULTS
                                                             : i_pop_count;
    assign cnt_w     = CW'(cnt_sat);
    assign fill_w    = CW'(r_fill);
    assign shortfall = fill_w < cnt_w;
    assign n_pop     = shortfall ? fill_w[lsm_pkg::COUNT_W-1:0] : cnt_sat;

    // chain of cells, cell 0 is the top
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic signed [lsm_pkg::WORD_W-1:0] from_up;
        logic signed [lsm_pkg::WORD_W-1:0] from_dn;
        if (g == 0) begin : g_top
            assign from_up = i_push_value;
        end else begin : g_mid_up
            assign from_up = cell_word[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign from_dn = '0;
        end else begin : g_mid_dn
            assign from_dn = cell_word[g+1];
        end
        lsm_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (shift),
            .i_from_up (from_up),
            .i_from_dn (from_dn),
            .o_word    (cell_word[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsm_pkg::S_IDLE: begin
                if (in_take && (i_cmd == lsm_pkg::CMD_MPOP)
                        && (n_pop > lsm_pkg::COUNT_W'(1))) begin
                    n_state = lsm_pkg::S_MPOP;
                end
            end
            lsm_pkg::S_MPOP: begin
                if (out_free && (r_remain == lsm_pkg::COUNT_W'(1))) begin
                    n_state = lsm_pkg::S_IDLE;
                end
            end
            default: n_state = lsm_pkg::S_IDLE;
        endcase
    end

    // shift controls, results and counters
    always_comb begin
        shift    = '0;
        emit     = 1'b0;
        e_word   = '0;
        e_valid  = 1'b0;
        e_status = lsm_pkg::ST_OK;
        e_last   = 1'b1;
        n_fill   = r_fill;
        n_remain = r_remain;
        n_short  = r_short;
        case (r_state)
            lsm_pkg::S_IDLE: begin
                if (in_take) begin
                    case (i_cmd)
                        lsm_pkg::CMD_PUSH: begin
                            emit = 1'b1;
                            if (full) begin
                                e_status = lsm_pkg::ST_OVF;
                            end else begin
                                shift.push = 1'b1;
                                n_fill     = r_fill + FW'(1);
                            end
                        end
                        lsm_pkg::CMD_POP: begin
                            emit = 1'b1;
                            if (empty) begin
                                e_status = lsm_pkg::ST_UNF;
                            end else begin
                                shift.pop = 1'b1;
                                e_word    = cell_word[0];
                                e_valid   = 1'b1;
                                n_fill    = r_fill - FW'(1);
                            end
                        end
                        lsm_pkg::CMD_MPOP: begin
                            emit = 1'b1;
                            if (n_pop != '0) begin
                                shift.pop = 1'b1;
                                e_word    = cell_word[0];
                                e_valid   = 1'b1;
                                n_fill    = r_fill - FW'(1);
                            end
                            e_last   = (n_pop <= lsm_pkg::COUNT_W'(1));
                            e_status = (e_last && shortfall) ? lsm_pkg::ST_SHORT
                                                             : lsm_pkg::ST_OK;
                            n_remain = n_pop - lsm_pkg::COUNT_W'(1);
                            n_short  = shortfall;
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
            lsm_pkg::S_MPOP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    shift.pop = 1'b1;
                    e_word    = cell_word[0];
                    e_valid   = 1'b1;
                    e_last    = (r_remain == lsm_pkg::COUNT_W'(1));
                    e_status  = (e_last && r_short) ? lsm_pkg::ST_SHORT
                                                    : lsm_pkg::ST_OK;
                    n_fill    = r_fill - FW'(1);
                    n_remain  = r_remain - lsm_pkg::COUNT_W'(1);
                end
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsm_pkg::S_IDLE;
            r_fill      <= '0;
            r_remain    <= '0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_remain <= n_remain;
            r_short  <= n_short;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_word_out   <= e_word;
            r_word_valid <= e_valid;
            r_status     <= e_status;
            r_last       <= e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_word_out   = r_word_out;
    assign o_word_valid = r_word_valid;
    assign o_status     = r_status;
    assign o_last       = r_last;

    `ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FW'(STACK_DEPTH),
        "fill level above stack depth")
    `ASSERT_NEVER(a_stream_count, i_clk, i_rst_n,
        (r_state == lsm_pkg::S_MPOP) && (r_remain == '0),
        "multi-pop streaming with nothing left")
    `ASSERT_CLK(a_ovf_keeps_fill, i_clk, i_rst_n,
        (in_take && (i_cmd == lsm_pkg::CMD_PUSH) && full) |=> $stable(r_fill),
        "overflowing push changed the fill level")
    `ASSERT_CLK(a_word_status, i_clk, i_rst_n,
        (o_out_valid && o_word_valid) |->
            (o_status == lsm_pkg::ST_OK || o_status == lsm_pkg::ST_SHORT),
        "popped word with an error status")

endmodule

// ----- tb/lifo_stack_with_multi_pop_tb.sv -----
// self-checking testbench for the multi-pop lifo stack
`timescale 1ns / 1ps

module lifo_stack_with_multi_pop_tb;

    localparam int STACK_DEPTH = 128;
    localparam int N_ITEMS = 420;
    localparam int MAX_REPORTS = 10;
    localparam logic [lsm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic signed [lsm_pkg::WORD_W-1:0] word;
        logic word_valid;
        logic [lsm_pkg::STATUS_W-1:0] status;
        logic last;
    } t_stack_result;

    class t_scoreboard;
        logic signed [lsm_pkg::WORD_W-1:0] words [STACK_DEPTH];
        int unsigned depth_used = 0;
        t_stack_result pending_results[$];
        int unsigned mismatches = 0;

        function void add_result(logic signed [lsm_pkg::WORD_W-1:0] word, logic word_valid,
                                 logic [lsm_pkg::STATUS_W-1:0] status, logic last);
            t_stack_result r;
            r.word = word;
            r.word_valid = word_valid;
            r.status = status;
            r.last = last;
            pending_results.push_back(r);
        endfunction

        function void note_command(logic [lsm_pkg::CMD_W-1:0] cmd,
                                   logic signed [lsm_pkg::WORD_W-1:0] value,
                                   logic [lsm_pkg::COUNT_W-1:0] count);
            int unsigned want;
            int unsigned take;
            case (cmd)
                lsm_pkg::CMD_PUSH: begin
                    if (depth_used >= STACK_DEPTH) begin
                        add_result('0, 1'b0, lsm_pkg::ST_OVF, 1'b1);
                    end else begin
                        words[depth_used] = value;
                        depth_used++;
                        add_result('0, 1'b0, lsm_pkg::ST_OK, 1'b1);
                    end
                end
                lsm_pkg::CMD_POP: begin
                    if (depth_used == 0) begin
                        add_result('0, 1'b0, lsm_pkg::ST_UNF, 1'b1);
                    end else begin
                        depth_used--;
                        add_result(words[depth_used], 1'b1, lsm_pkg::ST_OK, 1'b1);
                    end
                end
                lsm_pkg::CMD_MPOP: begin
                    want = (count > lsm_pkg::MAX_RESULTS) ? 32'(lsm_pkg::MAX_RESULTS)
                                                          : 32'(count);
                    take = (want < depth_used) ? want : depth_used;
                    if (take == 0) begin
                        add_result('0, 1'b0,
                                   (want != 0) ? lsm_pkg::ST_SHORT : lsm_pkg::ST_OK, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < take; i++) begin
                            depth_used--;
                            add_result(words[depth_used], 1'b1,
                                       (i + 1 == take && take < want) ? lsm_pkg::ST_SHORT
                                                                      : lsm_pkg::ST_OK,
                                       i + 1 == take);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_stack_result got);
            t_stack_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result word %0d valid %0b status %0d last %0b",
                             $time, got.word, got.word_valid, got.status, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.word !== want.word || got.word_valid !== want.word_valid ||
                    got.status !== want.status || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch expected word %0d valid %0b status %0d last %0b, %s",
                             $time, want.word, want.word_valid, want.status, want.last,
                             $sformatf("got word %0d valid %0b status %0d last %0b",
                                       got.word, got.word_valid, got.status, got.last));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [lsm_pkg::CMD_W-1:0] i_cmd = lsm_pkg::CMD_PUSH;
    logic signed [lsm_pkg::WORD_W-1:0] i_push_value = '0;
    logic [lsm_pkg::COUNT_W-1:0] i_pop_count = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [lsm_pkg::WORD_W-1:0] o_word_out;
    logic o_word_valid;
    logic [lsm_pkg::STATUS_W-1:0] o_status;
    logic o_last;

    t_scoreboard sb = new();
    int unsigned n_items = 0;
    bit in_gaps = 1'b1;
    bit out_gaps = 1'b1;
    bit result_seen = 1'b0;
    t_stack_result sampled;

    lifo_stack_with_multi_pop #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_cmd(i_cmd),
        .i_push_value(i_push_value),
        .i_pop_count(i_pop_count),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_word_out(o_word_out),
        .o_word_valid(o_word_valid),
        .o_status(o_status),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // outputs only move at the rising edge, so the falling edge sees what the next edge takes
    always @(negedge i_clk) begin
        result_seen = i_rst_n && o_out_valid === 1'b1 && !i_out_stall;
        sampled.word = o_word_out;
        sampled.word_valid = o_word_valid;
        sampled.status = o_status;
        sampled.last = o_last;
    end

    always @(posedge i_clk) begin
        if (result_seen)
            sb.check_result(sampled);
        i_out_stall <= out_gaps && ($urandom_range(0, 99) < 35);
    end

    function automatic logic signed [lsm_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: random_word = 32'sh7FFF_FFFF;
            1: random_word = 32'sh8000_0000;
            2: random_word = -32'sd1;
            default: random_word = $urandom;
        endcase
    endfunction

    function automatic logic [lsm_pkg::COUNT_W-1:0] random_count();
        random_count = lsm_pkg::COUNT_W'($urandom);
    endfunction

    task automatic send_command(input logic [lsm_pkg::CMD_W-1:0] cmd,
                                input logic signed [lsm_pkg::WORD_W-1:0] value,
                                input logic [lsm_pkg::COUNT_W-1:0] count);
        logic taken;
        if (in_gaps) begin
            while ($urandom_range(0, 99) < 35) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_push_value <= value;
        i_pop_count <= count;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_command(cmd, value, count);
        if (cmd != CMD_UNUSED)
            n_items++;
    endtask

    // hold off new commands until every outstanding result has come back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending_results.size() != 0);
    endtask

    initial begin
        int unsigned pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stack corner cases, then extreme words pushed and popped
        send_command(lsm_pkg::CMD_POP, random_word(), random_count());
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd0);
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd5);
        send_command(CMD_UNUSED, random_word(), random_count());
        send_command(lsm_pkg::CMD_PUSH, 32'sh7FFF_FFFF, 7'd127);
        send_command(lsm_pkg::CMD_PUSH, 32'sh8000_0000, 7'd0);
        send_command(lsm_pkg::CMD_PUSH, 32'sd0, 7'd64);
        send_command(lsm_pkg::CMD_PUSH, -32'sd1, 7'd65);
        send_command(lsm_pkg::CMD_PUSH, 32'sh5555_5555, 7'd1);
        send_command(lsm_pkg::CMD_PUSH, 32'shAAAA_AAAA, 7'd2);
        send_command(CMD_UNUSED, random_word(), random_count());
        send_command(lsm_pkg::CMD_POP, random_word(), 7'd3);
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd0);
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd2);
        // three left, count saturates and the stack runs out early
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd127);
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd1);
        send_command(lsm_pkg::CMD_POP, random_word(), 7'd0);

        // fill past the top, then drain with two full-size multi-pops
        repeat (STACK_DEPTH + 2)
            send_command(lsm_pkg::CMD_PUSH, random_word(), random_count());
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd127);
        send_command(lsm_pkg::CMD_MPOP, random_word(), 7'd100);
        send_command(lsm_pkg::CMD_POP, random_word(), random_count());
        wait_for_drain();

        while (n_items < N_ITEMS) begin
            in_gaps = !(n_items >= 230 && n_items < 330);
            out_gaps = in_gaps;
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                repeat ($urandom_range(1, (pick == 0) ? 100 : 12))
                    send_command(lsm_pkg::CMD_PUSH, random_word(), random_count());
            end else if (pick < 12) begin
                send_command(lsm_pkg::CMD_MPOP, random_word(),
                             lsm_pkg::COUNT_W'(($urandom_range(0, 3) == 0)
                                               ? $urandom_range(0, 127)
                                               : $urandom_range(0, 12)));
            end else if (pick < 18) begin
                send_command(lsm_pkg::CMD_POP, random_word(), random_count());
            end else if (pick < 19) begin
                send_command(CMD_UNUSED, random_word(), random_count());
            end else begin
                wait_for_drain();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
